FILE: design/rrd_pkg.sv
// Shared types and constants for the reader response deframer.
package rrd_pkg;

  localparam logic [7:0] MIN_FRAME_LENGTH = 8'd5;
  localparam logic [7:0] LIST_COMMAND     = 8'h11;
  localparam logic [7:0] STATUS_OK        = 8'h00;
  localparam logic [7:0] STATUS_NO_CARD   = 8'h01;

  // Frame byte positions
  localparam logic [7:0] POS_LENGTH  = 8'd0;
  localparam logic [7:0] POS_COMMAND = 8'd2;
  localparam logic [7:0] POS_STATUS  = 8'd3;
  localparam logic [7:0] POS_PAYLOAD = 8'd4;

  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd1;
  localparam logic [2:0] VERDICT_COMMAND  = 3'd2;
  localparam logic [2:0] VERDICT_DEVICE   = 3'd3;
  localparam logic [2:0] VERDICT_LENGTH   = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic [7:0] device_status;
    logic       frame_last;
  } rrd_result_t;

endpackage

FILE: design/reader_response_deframer.sv
// Reader response deframer: byte-wise frame check with tentative payload output.
// A word is registered at input, then processed into the two-entry result queue, from
// which its result is presented and can be taken when the output is not stalled.
// Throughput: one word per cycle while that queue is not full; it absorbs output stalls.
// Reset (rst, synchronous): idle, awaiting a length word, queue empty,
// expected_command cleared to zero.
module reader_response_deframer import rrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [7:0] payload_byte,
  output logic [2:0] verdict,
  output logic [7:0] device_status,
  output logic       frame_last
);

  logic [7:0]  expected_command;
  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        stage_advance;
  logic        queue_full;
  logic        res_valid;
  rrd_result_t res;
  rrd_result_t out_data;

  assign stage_advance = stage_valid && !queue_full;
  assign in_ready      = !stage_valid || !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= '0;
    end else if (cfg_write) begin
      expected_command <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stage_byte <= rx_byte;
  end

  rrd_frame_ctrl u_frame_ctrl (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (stage_advance),
    .rx_byte          (stage_byte),
    .expected_command (expected_command),
    .res_valid        (res_valid),
    .res              (res)
  );

  rrd_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign result_kind   = out_data.result_kind;
  assign payload_byte  = out_data.payload_byte;
  assign verdict       = out_data.verdict;
  assign device_status = out_data.device_status;
  assign frame_last    = out_data.frame_last;

endmodule

FILE: design/rrd_frame_ctrl.sv
// Frame tracking state and per-word result formation.
module rrd_frame_ctrl import rrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  expected_command,
  output logic        res_valid,
  output rrd_result_t res
);

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] held_status, held_status_next;
  logic       command_mismatch, command_mismatch_next;
  logic       is_last;
  logic       dev_err;

  assign is_last = ({1'b0, byte_position} + 9'd1) >= {1'b0, frame_length};
  assign dev_err = (expected_command != LIST_COMMAND) && (held_status != STATUS_OK) &&
                   (held_status != STATUS_NO_CARD);

  always_comb begin
    byte_position_next    = byte_position;
    frame_length_next     = frame_length;
    running_xor_next      = running_xor;
    held_status_next      = held_status;
    command_mismatch_next = command_mismatch;
    res_valid             = 1'b0;
    res                   = '0;
    if (byte_valid) begin
      if (byte_position == POS_LENGTH) begin
        if (rx_byte < MIN_FRAME_LENGTH) begin
          res_valid         = 1'b1;
          res.result_kind   = KIND_VERDICT;
          res.verdict       = VERDICT_LENGTH;
          res.frame_last    = 1'b1;
        end else begin
          frame_length_next     = rx_byte;
          running_xor_next      = rx_byte;
          held_status_next      = '0;
          command_mismatch_next = 1'b0;
          byte_position_next    = 8'd1;
        end
      end else if (is_last) begin
        // checksum word: verdict, then back to idle
        res_valid         = 1'b1;
        res.result_kind   = KIND_VERDICT;
        res.device_status = held_status;
        res.frame_last    = 1'b1;
        if (command_mismatch)
          res.verdict = VERDICT_COMMAND;
        else if (dev_err)
          res.verdict = VERDICT_DEVICE;
        else if (running_xor != rx_byte)
          res.verdict = VERDICT_CHECKSUM;
        else
          res.verdict = VERDICT_OK;
        byte_position_next    = '0;
        frame_length_next     = '0;
        running_xor_next      = '0;
        held_status_next      = '0;
        command_mismatch_next = 1'b0;
      end else begin
        running_xor_next   = running_xor ^ rx_byte;
        byte_position_next = byte_position + 8'd1;
        if (byte_position == POS_COMMAND) begin
          command_mismatch_next = (rx_byte != expected_command);
        end else if (byte_position == POS_STATUS) begin
          held_status_next = rx_byte;
        end else if (byte_position >= POS_PAYLOAD) begin
          res_valid        = 1'b1;
          res.result_kind  = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      frame_length     <= '0;
      running_xor      <= '0;
      held_status      <= '0;
      command_mismatch <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      frame_length     <= frame_length_next;
      running_xor      <= running_xor_next;
      held_status      <= held_status_next;
      command_mismatch <= command_mismatch_next;
    end
  end

endmodule

FILE: design/rrd_out_queue.sv
// Two-entry result queue; decouples result formation from output stalls.
module rrd_out_queue import rrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  rrd_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_ready,
  output rrd_result_t out_data
);

  rrd_result_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/rrd_checker.sv
// Port-level checks for the reader response deframer, bound to the top level.
module rrd_checker import rrd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [7:0] payload_byte,
  input logic [2:0] verdict,
  input logic [7:0] device_status,
  input logic       frame_last
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result_kind) && $stable(payload_byte) &&
      $stable(verdict) && $stable(device_status) && $stable(frame_last))
    else $error("result word changed while stalled");

  a_last_on_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_last == result_kind)
    else $error("frame_last does not match verdict word");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |-> verdict == VERDICT_OK &&
      device_status == 8'd0)
    else $error("payload word carries verdict fields");

  a_length_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_VERDICT && verdict == VERDICT_LENGTH |->
      device_status == 8'd0 && payload_byte == 8'd0)
    else $error("bad length verdict carries frame data");

endmodule

bind reader_response_deframer rrd_checker u_rrd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_kind   (result_kind),
  .payload_byte  (payload_byte),
  .verdict       (verdict),
  .device_status (device_status),
  .frame_last    (frame_last)
);
